/* src/deq_pkg.sv */
// Shared types and constants of the double-ended queue.
// Holds the operation and status codes and the controller state type.
// No dependencies.
package deq_pkg;

  localparam int unsigned DATA_W = 32;

  // What the front and back fields read when the queue holds nothing
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } deq_func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } deq_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_FILL = 1'b1
  } deq_state_e;

endpackage

/* src/deq_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth come from parameters. No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/double_ended_queue.sv */
// Bounded double-ended queue of 32-bit words kept in a circular RAM.
// Depends on deq_pkg and deq_ram.
//
// Slave channel: s_axis_tuser_i carries the operation (push front, push back,
// pop front, pop back), s_axis_tdata_i the value to push. Every accepted
// transaction yields exactly one master transaction with the popped value, a
// status (ok, overflow, underflow), the entry count, the empty flag and the
// front and back entries after the operation (all ones when empty).
// Front and back entries are cached in registers; the RAM is read only to
// refill one of them after a pop that leaves two or more entries behind.
// Pushes, faults and pops that leave at most one entry load the result into the
// output register on acceptance; a refilling pop loads it from the FILL state
// after the registered RAM read. Throughput: one transaction per cycle while the
// receiver keeps up, except refilling pops, which hold the slave side in FILL while the read completes.
// A full queue rejects a push and an empty queue a pop, in status only; nothing changes.
// Reset clears the pointers and the count; the RAM is never read before written.
// When the receiver stalls, the result holds in the output register and one new
// transaction is taken only as that register drains.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] push_value
  input  logic [31:0]                    s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]                     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // popped_value, status, entry_count, is_empty, front_value, back_value
  output logic [((2*32+32+2+1+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned DW          = deq_pkg::DATA_W;
  localparam int unsigned AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW          = $clog2(DEPTH+1);
  localparam int unsigned OUT_W       = 3*DW + 2 + 1 + CW;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx);
    step_up = (idx == AW'(DEPTH-1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx);
    step_down = (idx == '0) ? AW'(DEPTH-1) : idx - AW'(1);
  endfunction

  deq_pkg::deq_state_e  state_q, state_d;
  logic [AW-1:0]        head_q, head_d;
  logic [AW-1:0]        tail_q, tail_d;
  logic [CW-1:0]        count_q, count_d;
  logic [DW-1:0]        front_q, front_d;
  logic [DW-1:0]        back_q, back_d;
  logic                 fill_front_q, fill_front_d;
  logic [DW-1:0]        pend_popped_q, pend_popped_d;

  logic                 out_valid_q, out_valid_d;
  logic [DW-1:0]        out_popped_q, out_popped_d;
  deq_pkg::deq_status_e out_status_q, out_status_d;
  logic [CW-1:0]        out_count_q, out_count_d;
  logic [DW-1:0]        out_front_q, out_front_d;
  logic [DW-1:0]        out_back_q, out_back_d;

  logic                 s_ready;
  logic                 in_fire;
  logic                 need_fill;
  logic                 out_load;
  deq_pkg::deq_func_e   func;
  logic                 is_full;
  logic                 is_empty_now;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;

  assign func         = deq_pkg::deq_func_e'(s_axis_tuser_i);
  assign is_full      = (count_q == CW'(DEPTH));
  assign is_empty_now = (count_q == '0);
  assign in_fire      = s_axis_tvalid_i && s_ready;

  // Reads and writes never target the same cycle: a write comes only from
  // an accepted push, a read only from an accepted pop, so no forwarding.
  deq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      deq_pkg::ST_IDLE: begin
        if (in_fire && need_fill) begin
          state_d = deq_pkg::ST_FILL;
        end
      end
      deq_pkg::ST_FILL: state_d = deq_pkg::ST_IDLE;
      default:          state_d = deq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    s_ready       = 1'b0;
    need_fill     = 1'b0;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = tail_q;
    ram_re        = 1'b0;
    ram_raddr     = step_up(head_q);
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    front_d       = front_q;
    back_d        = back_q;
    fill_front_d  = fill_front_q;
    pend_popped_d = pend_popped_q;
    out_popped_d  = '0;
    out_status_d  = deq_pkg::STATUS_OK;

    case (state_q)
      deq_pkg::ST_IDLE: begin
        s_ready = !out_valid_q || m_axis_tready_i;
        case (func)
          deq_pkg::FUNC_PUSH_FRONT: begin
            if (is_full) begin
              out_status_d = deq_pkg::STATUS_OVERFLOW;
            end else begin
              ram_we    = in_fire;
              ram_waddr = step_down(head_q);
              head_d    = step_down(head_q);
              count_d   = count_q + CW'(1);
              front_d   = s_axis_tdata_i;
              if (is_empty_now) begin
                back_d = s_axis_tdata_i;
              end
            end
          end
          deq_pkg::FUNC_PUSH_BACK: begin
            if (is_full) begin
              out_status_d = deq_pkg::STATUS_OVERFLOW;
            end else begin
              ram_we    = in_fire;
              ram_waddr = tail_q;
              tail_d    = step_up(tail_q);
              count_d   = count_q + CW'(1);
              back_d    = s_axis_tdata_i;
              if (is_empty_now) begin
                front_d = s_axis_tdata_i;
              end
            end
          end
          deq_pkg::FUNC_POP_FRONT: begin
            if (is_empty_now) begin
              out_status_d = deq_pkg::STATUS_UNDERFLOW;
            end else begin
              out_popped_d  = front_q;
              pend_popped_d = front_q;
              head_d        = step_up(head_q);
              count_d       = count_q - CW'(1);
              fill_front_d  = 1'b1;
              // Two entries: the back entry becomes the front one
              if (count_q == CW'(2)) begin
                front_d = back_q;
              end else if (count_q > CW'(2)) begin
                need_fill = 1'b1;
                ram_re    = in_fire;
                ram_raddr = step_up(head_q);
              end
            end
          end
          deq_pkg::FUNC_POP_BACK: begin
            if (is_empty_now) begin
              out_status_d = deq_pkg::STATUS_UNDERFLOW;
            end else begin
              out_popped_d  = back_q;
              pend_popped_d = back_q;
              tail_d        = step_down(tail_q);
              count_d       = count_q - CW'(1);
              fill_front_d  = 1'b0;
              if (count_q == CW'(2)) begin
                back_d = front_q;
              end else if (count_q > CW'(2)) begin
                need_fill = 1'b1;
                ram_re    = in_fire;
                ram_raddr = step_down(step_down(tail_q));
              end
            end
          end
          default: ;
        endcase
        out_load = in_fire && !need_fill;
        if (!in_fire) begin
          head_d  = head_q;
          tail_d  = tail_q;
          count_d = count_q;
          front_d = front_q;
          back_d  = back_q;
        end
      end
      deq_pkg::ST_FILL: begin
        // Pick up the refilled entry and finish the pending pop
        out_load     = 1'b1;
        out_popped_d = pend_popped_q;
        if (fill_front_q) begin
          front_d = ram_rdata;
        end else begin
          back_d = ram_rdata;
        end
      end
      default: ;
    endcase

    out_count_d = count_d;
    out_front_d = (count_d == '0) ? deq_pkg::EMPTY_VALUE : front_d;
    out_back_d  = (count_d == '0) ? deq_pkg::EMPTY_VALUE : back_d;
    out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q       <= front_d;
    back_q        <= back_d;
    fill_front_q  <= fill_front_d;
    pend_popped_q <= pend_popped_d;
    if (out_load) begin
      out_popped_q <= out_popped_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
      out_front_q  <= out_front_d;
      out_back_q   <= out_back_d;
    end
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_back_q, out_front_q, (out_count_q == '0),
                                         out_count_q, out_status_q, out_popped_q});

  // Assertions

  ast_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  ast_fill_output_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == deq_pkg::ST_FILL) |-> !out_valid_q)
    else $error("refill cycle found output register occupied");

  ast_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == deq_pkg::STATUS_OVERFLOW)
      |-> (out_count_q == CW'(DEPTH)))
    else $error("overflow reported on a queue that is not full");

  ast_underflow_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == deq_pkg::STATUS_UNDERFLOW)
      |-> (out_count_q == '0 && out_popped_q == '0))
    else $error("underflow reported with entries or a popped value");

  ast_pop_refill_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && need_fill) |=> (state_q == deq_pkg::ST_FILL && count_q >= CW'(2)))
    else $error("refill read issued without enough entries left");

endmodule

/* tb/tb_double_ended_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: a directed table, then random operations.
// Results come from the typed table rows, else from a ring-buffer model, and are checked field by field in order.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned RES_W      = ((2*32 + 32 + 2 + 1 + CNT_W + 7) / 8) * 8;
  localparam int unsigned PLAN_LEN   = 25;
  localparam int unsigned RANDOM_OPS = 1875;
  localparam int unsigned IDLE_LIMIT = 4000;

  // Bit order matches m_axis_tdata_o, lowest field last
  typedef struct packed {
    logic [31:0] back_value;
    logic [31:0] front_value;
    logic        is_empty;
    logic [CNT_W-1:0] entry_count;
    deq_pkg::deq_status_e status;
    logic [31:0] popped_value;
  } deq_result_t;

  typedef struct packed {
    deq_pkg::deq_func_e op;
    logic [31:0] value;
    logic        typed;
    deq_result_t result;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [31:0]      s_axis_tdata_i;
  logic [1:0]       s_axis_tuser_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [RES_W-1:0] m_axis_tdata_o;

  // Ring-buffer model of the queue
  logic [31:0] ring_mem [DEPTH];
  int unsigned ring_head;
  int unsigned ring_tail;
  int unsigned ring_fill;

  deq_result_t pending_results[$];
  int unsigned errors;
  int unsigned n_ops, n_overflow, n_underflow, n_pops, n_checked;
  int unsigned idle_cycles;
  int unsigned op_mode;
  logic        calm;

  plan_row_t plan_rows [PLAN_LEN] = '{
    '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd0, deq_pkg::STATUS_UNDERFLOW, 32'h0}},
    '{deq_pkg::FUNC_POP_BACK,   32'h1234_5678, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd0, deq_pkg::STATUS_UNDERFLOW, 32'h0}},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd1, deq_pkg::STATUS_OK, 32'h0}},
    '{deq_pkg::FUNC_PUSH_BACK,  32'h8000_0000, 1'b1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 5'd2, deq_pkg::STATUS_OK, 32'h0}},
    '{deq_pkg::FUNC_POP_BACK,   32'h0000_0000, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd1, deq_pkg::STATUS_OK, 32'h8000_0000}},
    '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd0, deq_pkg::STATUS_OK, 32'h7FFF_FFFF}},
    // Fill to capacity from both ends, wrapping the head below zero, push twice into the full queue, then pop the front
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'h8000_0000, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h00FF_00FF, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hFF00_FF00, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h0000_FFFF, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hFFFF_0000, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'h1357_9BDF, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hECA8_6420, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '0},
    '{deq_pkg::FUNC_PUSH_BACK,  32'hCAFE_F00D, 1'b0, '0},
    '{deq_pkg::FUNC_POP_FRONT,  32'h0000_0000, 1'b0, '0}
  };

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advance the model by one operation and return the result it yields
  function automatic deq_result_t apply_op(deq_pkg::deq_func_e op, logic [31:0] value);
    deq_result_t r;
    r = '0;
    r.status = deq_pkg::STATUS_OK;
    n_ops++;
    if (op == deq_pkg::FUNC_PUSH_FRONT || op == deq_pkg::FUNC_PUSH_BACK) begin
      if (ring_fill == DEPTH) begin
        r.status = deq_pkg::STATUS_OVERFLOW;
        n_overflow++;
      end else if (op == deq_pkg::FUNC_PUSH_FRONT) begin
        ring_head = (ring_head == 0) ? DEPTH - 1 : ring_head - 1;
        ring_mem[ring_head] = value;
        ring_fill++;
      end else begin
        ring_mem[ring_tail] = value;
        ring_tail = (ring_tail == DEPTH - 1) ? 0 : ring_tail + 1;
        ring_fill++;
      end
    end else begin
      if (ring_fill == 0) begin
        r.status = deq_pkg::STATUS_UNDERFLOW;
        n_underflow++;
      end else if (op == deq_pkg::FUNC_POP_FRONT) begin
        r.popped_value = ring_mem[ring_head];
        ring_head = (ring_head == DEPTH - 1) ? 0 : ring_head + 1;
        ring_fill--;
        n_pops++;
      end else begin
        ring_tail = (ring_tail == 0) ? DEPTH - 1 : ring_tail - 1;
        r.popped_value = ring_mem[ring_tail];
        ring_fill--;
        n_pops++;
      end
    end
    r.entry_count = CNT_W'(ring_fill);
    r.is_empty    = (ring_fill == 0);
    if (ring_fill == 0) begin
      r.front_value = deq_pkg::EMPTY_VALUE;
      r.back_value  = deq_pkg::EMPTY_VALUE;
    end else begin
      r.front_value = ring_mem[ring_head];
      r.back_value  = ring_mem[(ring_tail == 0) ? DEPTH - 1 : ring_tail - 1];
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Fill mode leans on pushes, drain mode on pops, so both full and empty get hit often
  function automatic deq_pkg::deq_func_e pick_op();
    int unsigned r;
    logic        is_push;
    r = $urandom_range(0, 99);
    case (op_mode)
      0:       is_push = (r < 85);
      1:       is_push = (r < 15);
      default: is_push = (r < 50);
    endcase
    if (is_push) begin
      return $urandom_range(0, 1) ? deq_pkg::FUNC_PUSH_BACK : deq_pkg::FUNC_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? deq_pkg::FUNC_POP_BACK : deq_pkg::FUNC_POP_FRONT;
  endfunction

  // Called at a falling edge; returns at the rising edge where the transaction lands
  task automatic send_op(input deq_pkg::deq_func_e op, input logic [31:0] value,
                         input int unsigned gap, input logic typed,
                         input deq_result_t typed_result);
    deq_result_t predicted;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_op(op, value);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Receiver: ready runs broken by stalls, now and then a long stretch with no stall
  initial begin
    int unsigned run_len;
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_axis_tready_i <= 1'b1;
      repeat (run_len) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    deq_result_t got;
    deq_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.popped_value !== want.popped_value) begin
          $error("popped_value: expected %h, got %h", want.popped_value, got.popped_value);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          errors++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
          errors++;
        end
        if (got.front_value !== want.front_value) begin
          $error("front_value: expected %h, got %h", want.front_value, got.front_value);
          errors++;
        end
        if (got.back_value !== want.back_value) begin
          $error("back_value: expected %h, got %h", want.back_value, got.back_value);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned seg_left;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = deq_pkg::FUNC_PUSH_FRONT;
    ring_head       = 0;
    ring_tail       = 0;
    ring_fill       = 0;
    errors          = 0;
    n_ops           = 0;
    n_overflow      = 0;
    n_underflow     = 0;
    n_pops          = 0;
    n_checked       = 0;
    idle_cycles     = 0;
    op_mode         = 2;
    calm            = 1'b0;
    seg_left        = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int unsigned i = 0; i < PLAN_LEN; i++) begin
      @(negedge clk_i);
      send_op(plan_rows[i].op, plan_rows[i].value, pick_gap(), plan_rows[i].typed,
              plan_rows[i].result);
    end

    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        op_mode  = $urandom_range(0, 2);
        calm     = ($urandom_range(0, 4) == 0);
      end
      seg_left--;
      @(negedge clk_i);
      send_op(pick_op(), pick_value(), calm ? 0 : pick_gap(), 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d queue operations under random gaps and stalls, %0d results checked",
             n_ops, n_checked);
    $display("  %0d pops, %0d overflows, %0d underflows", n_pops, n_overflow, n_underflow);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d field mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
